/* rtl/xds_packet_assembler_defines.svh */
// Assertion macros for the XDS packet assembler checker.
// Depends on nothing; the including scope provides clock and reset.
`ifndef XDS_PACKET_ASSEMBLER_DEFINES_SVH
`define XDS_PACKET_ASSEMBLER_DEFINES_SVH

// Plain property, sampled on the rising clock, off during reset.
`define XPA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("xds_packet_assembler: check failed");

// Same-cycle implication.
`define XPA_ASSERT_IMP(lbl, ante, cons) \
   `XPA_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define XPA_ASSERT_NEXT(lbl, ante, cons) \
   `XPA_ASSERT(lbl, (ante) |=> (cons))

`endif

/* rtl/xpa_pkg.sv */
// Shared types and constants of the XDS packet assembler.
// Depends on nothing; the top level, the sequencer and the checker import it.
package xpa_pkg;

   localparam int XPA_NUM_CLASSES = 7;
   localparam int XPA_MAX_PAYLOAD = 32;
   localparam int XPA_CIDX_W      = $clog2(XPA_NUM_CLASSES);

   // Control codes in header mode and word patterns in payload mode
   localparam logic [3:0] XPA_CODE_NONE = 4'h0;
   localparam logic [3:0] XPA_CODE_END  = 4'hF;
   localparam logic [3:0] XPA_NIB_CTRL  = 4'h1;
   localparam logic [7:0] XPA_END_BYTE  = 8'h8F;
   localparam logic [6:0] XPA_CHAR_MIN  = 7'h20;

   typedef enum logic [1:0] {
      XPA_ST_OK    = 2'd0,
      XPA_ST_ERROR = 2'd1,
      XPA_ST_READY = 2'd2
   } xpa_status_type;

   typedef enum logic [1:0] {
      XPA_DT_NONE     = 2'd0,
      XPA_DT_STRUCT   = 2'd1,
      XPA_DT_CHECKSUM = 2'd2,
      XPA_DT_CHARS    = 2'd3
   } xpa_detail_type;

   typedef enum logic [2:0] {
      XPA_S_IDLE,
      XPA_S_LOOK,
      XPA_S_SUM,
      XPA_S_EMIT,
      XPA_S_RESP
   } xpa_state_type;

   typedef struct packed {
      xpa_status_type status;
      xpa_detail_type detail;
      logic [3:0]     packet_class;
      logic [6:0]     packet_type;
      logic [5:0]     payload_length;
      logic [6:0]     first_char;
      logic [6:0]     second_char;
      logic           pair_valid;
      logic           last;
   } xpa_result_type;

endpackage

/* rtl/xds_packet_assembler.sv */
// Top level of the XDS packet assembler: class table RAM, payload RAM,
// sequencer and result register. Uses xpa_pkg, xpa_ram and xpa_seq.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  caption_word[15:0]
//   rsp_     out        rsp_valid/rsp_stall  status, detail, packet_class,
//                                            packet_type, payload_length,
//                                            first_char, second_char,
//                                            pair_valid, last
//
// One word is in work at a time: an ordinary word is accepted, reads the
// class table and yields a result. An end code checksums n stored pairs,
// then emits n pair words, or one word, one per cycle unless rsp_ stalls.
// The result register lets the next word in while a result waits.
// Reset is synchronous: clear control state and class valid bits, not RAMs.
// A stall on rsp_ holds the result register and pauses emission.
module xds_packet_assembler
   import xpa_pkg::*;
#(
   parameter int MAX_PAYLOAD = XPA_MAX_PAYLOAD
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_caption_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_detail,
   output logic [3:0]  rsp_packet_class,
   output logic [6:0]  rsp_packet_type,
   output logic [5:0]  rsp_payload_length,
   output logic [6:0]  rsp_first_char,
   output logic [6:0]  rsp_second_char,
   output logic        rsp_pair_valid,
   output logic        rsp_last
);

   localparam int PAIRS   = MAX_PAYLOAD / 2;
   localparam int PAIR_W  = $clog2(PAIRS + 1);
   localparam int CLS_W   = 4 + 7 + PAIR_W;
   localparam int PDEPTH  = XPA_NUM_CLASSES * PAIRS;
   localparam int PADDR_W = $clog2(PDEPTH);

   // Class table: start code, type code, stored pair count per class
   logic                  cls_we;
   logic [XPA_CIDX_W-1:0] cls_waddr;
   logic [CLS_W-1:0]      cls_wdata;
   logic                  cls_re;
   logic [XPA_CIDX_W-1:0] cls_raddr;
   logic [CLS_W-1:0]      cls_rdata;

   // Payload store: one entry holds a character pair
   logic                  pair_we;
   logic [PADDR_W-1:0]    pair_waddr;
   logic [13:0]           pair_wdata;
   logic                  pair_re;
   logic [PADDR_W-1:0]    pair_raddr;
   logic [13:0]           pair_rdata;

   logic                  res_ready;
   logic                  res_load;
   xpa_result_type        res;

   logic                  rsp_valid_ff;
   xpa_result_type        rsp_word_ff;

   xpa_ram #(
      .WIDTH (CLS_W),
      .DEPTH (XPA_NUM_CLASSES)
   ) u_cls_ram (
      .clock (clock),
      .we    (cls_we),
      .waddr (cls_waddr),
      .wdata (cls_wdata),
      .re    (cls_re),
      .raddr (cls_raddr),
      .rdata (cls_rdata)
   );

   xpa_ram #(
      .WIDTH (14),
      .DEPTH (PDEPTH)
   ) u_pair_ram (
      .clock (clock),
      .we    (pair_we),
      .waddr (pair_waddr),
      .wdata (pair_wdata),
      .re    (pair_re),
      .raddr (pair_raddr),
      .rdata (pair_rdata)
   );

   xpa_seq #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_caption_word (req_caption_word),
      .res_ready        (res_ready),
      .res_load         (res_load),
      .res              (res),
      .cls_we           (cls_we),
      .cls_waddr        (cls_waddr),
      .cls_wdata        (cls_wdata),
      .cls_re           (cls_re),
      .cls_raddr        (cls_raddr),
      .cls_rdata        (cls_rdata),
      .pair_we          (pair_we),
      .pair_waddr       (pair_waddr),
      .pair_wdata       (pair_wdata),
      .pair_re          (pair_re),
      .pair_raddr       (pair_raddr),
      .pair_rdata       (pair_rdata)
   );

   // Take a new result when the register is empty or its word leaves now
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      // hold the word while stalled, load only on a fresh result
      if (res_load) begin
         rsp_word_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_word_ff.status;
   assign rsp_detail         = rsp_word_ff.detail;
   assign rsp_packet_class   = rsp_word_ff.packet_class;
   assign rsp_packet_type    = rsp_word_ff.packet_type;
   assign rsp_payload_length = rsp_word_ff.payload_length;
   assign rsp_first_char     = rsp_word_ff.first_char;
   assign rsp_second_char    = rsp_word_ff.second_char;
   assign rsp_pair_valid     = rsp_word_ff.pair_valid;
   assign rsp_last           = rsp_word_ff.last;

endmodule

/* rtl/xpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module xpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/xpa_seq.sv */
// Sequencer of the XDS packet assembler: decodes words, updates the class
// table and payload RAMs, runs the checksum and emits packets. Uses xpa_pkg.
module xpa_seq
   import xpa_pkg::*;
#(
   parameter  int MAX_PAYLOAD = XPA_MAX_PAYLOAD,
   localparam int PAIRS       = MAX_PAYLOAD / 2,
   localparam int PAIR_W      = $clog2(PAIRS + 1),
   localparam int CLS_W       = 4 + 7 + PAIR_W,
   localparam int PADDR_W     = $clog2(XPA_NUM_CLASSES * PAIRS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [15:0]           req_caption_word,
   input  logic                  res_ready,
   output logic                  res_load,
   output xpa_result_type        res,
   output logic                  cls_we,
   output logic [XPA_CIDX_W-1:0] cls_waddr,
   output logic [CLS_W-1:0]      cls_wdata,
   output logic                  cls_re,
   output logic [XPA_CIDX_W-1:0] cls_raddr,
   input  logic [CLS_W-1:0]      cls_rdata,
   output logic                  pair_we,
   output logic [PADDR_W-1:0]    pair_waddr,
   output logic [13:0]           pair_wdata,
   output logic                  pair_re,
   output logic [PADDR_W-1:0]    pair_raddr,
   input  logic [13:0]           pair_rdata
);

   localparam logic [XPA_CIDX_W-1:0] LAST_CIDX = XPA_CIDX_W'(XPA_NUM_CLASSES);

   function automatic logic type_ok(input logic [3:0] code, input logic [6:0] t);
      logic ok;
      ok = 1'b0;
      unique case (code) inside
         4'h1, 4'h3: ok = (t <= 7'h17);
         4'h5:       ok = (t <= 7'h04);
         4'h7:       ok = (t <= 7'h04) || ((t >= 7'h40) && (t <= 7'h43));
         4'h9:       ok = (t <= 7'h02);
         4'hB, 4'hD: ok = 1'b1;
         default:    ok = 1'b0;
      endcase
      return ok && (t != 7'h00);
   endfunction

   function automatic xpa_result_type single(input xpa_status_type st,
                                             input xpa_detail_type dt);
      xpa_result_type r;
      r        = '0;
      r.status = st;
      r.detail = dt;
      r.last   = 1'b1;
      return r;
   endfunction

   xpa_state_type            state_ff, state_in;
   logic [15:0]              word_ff, word_in;
   logic                     in_payload_ff, in_payload_in;
   logic [XPA_CIDX_W-1:0]    active_ff, active_in;
   logic [XPA_CIDX_W-1:0]    cidx_ff, cidx_in;
   logic [6:0]               sum_ff, sum_in;
   logic [PAIR_W-1:0]        k_ff, k_in;
   logic [PAIR_W-1:0]        n_ff, n_in;
   logic [3:0]               start_ff, start_in;
   logic [6:0]               type_ff, type_in;
   xpa_result_type           pend_ff, pend_in;
   logic [XPA_NUM_CLASSES-1:0] cls_valid_ff;

   logic [3:0]               req_code;
   logic [XPA_CIDX_W-1:0]    req_cidx;
   logic                     cls_hit;
   logic [3:0]               r_start;
   logic [6:0]               r_type;
   logic [PAIR_W-1:0]        r_pairs;
   logic [3:0]               h_code;
   logic [6:0]               c1, c2;
   logic                     chars_ok;
   logic [PADDR_W-1:0]       pbase;
   logic [PAIR_W-1:0]        k_next;

   // Table index of the incoming word: header code, or the active class
   assign req_code = req_caption_word[11:8];
   assign req_cidx = in_payload_ff ? active_ff :
                     (req_code[0] ? req_code[3:1] : req_code[3:1] - 1'b1);

   // Entries never written read as the reset value, all zero
   assign cls_hit = (cidx_ff < LAST_CIDX) ? cls_valid_ff[cidx_ff] : 1'b0;
   assign r_start = cls_hit ? cls_rdata[CLS_W-1 -: 4] : 4'h0;
   assign r_type  = cls_hit ? cls_rdata[PAIR_W +: 7] : 7'h00;
   assign r_pairs = cls_hit ? cls_rdata[PAIR_W-1:0] : '0;

   assign h_code   = word_ff[11:8];
   assign c1       = word_ff[14:8];
   assign c2       = word_ff[6:0];
   assign chars_ok = ((c1 == 7'h00) || (c1 >= XPA_CHAR_MIN)) &&
                     ((c2 == 7'h00) || (c2 >= XPA_CHAR_MIN));
   assign pbase    = PADDR_W'(active_ff * PAIRS);
   assign k_next   = k_ff + PAIR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= XPA_S_IDLE;
         in_payload_ff <= 1'b0;
         active_ff     <= '0;
         cls_valid_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         in_payload_ff <= in_payload_in;
         active_ff     <= active_in;
         if (cls_we) begin
            cls_valid_ff[cls_waddr] <= 1'b1;
         end
      end
      word_ff  <= word_in;
      cidx_ff  <= cidx_in;
      sum_ff   <= sum_in;
      k_ff     <= k_in;
      n_ff     <= n_in;
      start_ff <= start_in;
      type_ff  <= type_in;
      pend_ff  <= pend_in;
   end

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      in_payload_in = in_payload_ff;
      active_in     = active_ff;
      cidx_in       = cidx_ff;
      sum_in        = sum_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      start_in      = start_ff;
      type_in       = type_ff;
      pend_in       = pend_ff;
      req_stall     = 1'b1;
      res_load      = 1'b0;
      res           = pend_ff;
      cls_we        = 1'b0;
      cls_waddr     = cidx_ff;
      cls_wdata     = {r_start, r_type, PAIR_W'(r_pairs + 1'b1)};
      cls_re        = 1'b0;
      cls_raddr     = req_cidx;
      pair_we       = 1'b0;
      pair_waddr    = pbase + PADDR_W'(r_pairs);
      pair_wdata    = {c1, c2};
      pair_re       = 1'b0;
      pair_raddr    = pbase + PADDR_W'(k_next);

      unique case (state_ff)
         XPA_S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               word_in  = req_caption_word;
               cidx_in  = req_cidx;
               cls_re   = (req_cidx < LAST_CIDX);
               state_in = XPA_S_LOOK;
            end
         end

         XPA_S_LOOK: begin
            state_in = XPA_S_RESP;
            pend_in  = single(XPA_ST_OK, XPA_DT_NONE);
            if (!in_payload_ff) begin
               if ((h_code == XPA_CODE_NONE) || (h_code == XPA_CODE_END)) begin
                  pend_in = single(XPA_ST_ERROR, XPA_DT_STRUCT);
               end else begin
                  in_payload_in = 1'b1;
                  if (h_code[0]) begin
                     // restart the class; a bad type leaves type zero
                     cls_we = 1'b1;
                     if (type_ok(h_code, word_ff[6:0])) begin
                        cls_wdata = {h_code, word_ff[6:0], PAIR_W'(0)};
                        active_in = cidx_ff;
                     end else begin
                        cls_wdata = {h_code, 7'h00, PAIR_W'(0)};
                        pend_in   = single(XPA_ST_ERROR, XPA_DT_STRUCT);
                     end
                  end else if (r_start != h_code - 4'h1) begin
                     pend_in = single(XPA_ST_ERROR, XPA_DT_STRUCT);
                  end else begin
                     active_in = cidx_ff;
                  end
               end
            end else if (word_ff[15:12] == XPA_NIB_CTRL) begin
               in_payload_in = 1'b0;
            end else if (active_ff >= LAST_CIDX) begin
               pend_in = single(XPA_ST_ERROR, XPA_DT_NONE);
            end else if (word_ff[15:8] == XPA_END_BYTE) begin
               in_payload_in = 1'b0;
               sum_in        = 7'({3'b000, r_start} + r_type + 7'h0F);
               start_in      = r_start;
               type_in       = r_type;
               n_in          = r_pairs;
               k_in          = '0;
               pair_re       = (r_pairs != '0);
               pair_raddr    = pbase;
               state_in      = XPA_S_SUM;
            end else if (!chars_ok) begin
               pend_in = single(XPA_ST_ERROR, XPA_DT_CHARS);
            end else if (r_pairs == PAIR_W'(PAIRS)) begin
               pend_in = single(XPA_ST_ERROR, XPA_DT_STRUCT);
            end else begin
               pair_we   = 1'b1;
               cls_we    = 1'b1;
               cls_waddr = active_ff;
            end
         end

         XPA_S_SUM: begin
            if (k_ff == n_ff) begin
               if (7'(sum_ff + word_ff[6:0]) != 7'h00) begin
                  pend_in  = single(XPA_ST_ERROR, XPA_DT_CHECKSUM);
                  state_in = XPA_S_RESP;
               end else if (n_ff == '0) begin
                  pend_in              = single(XPA_ST_READY, XPA_DT_NONE);
                  pend_in.packet_class = start_ff;
                  pend_in.packet_type  = type_ff;
                  state_in             = XPA_S_RESP;
               end else begin
                  k_in       = '0;
                  pair_re    = 1'b1;
                  pair_raddr = pbase;
                  state_in   = XPA_S_EMIT;
               end
            end else begin
               sum_in  = 7'(sum_ff + pair_rdata[13:7] + pair_rdata[6:0]);
               k_in    = k_next;
               pair_re = (k_next != n_ff);
            end
         end

         XPA_S_EMIT: begin
            res.status         = XPA_ST_READY;
            res.detail         = XPA_DT_NONE;
            res.packet_class   = start_ff;
            res.packet_type    = type_ff;
            res.payload_length = 6'({n_ff, 1'b0});
            res.first_char     = pair_rdata[13:7];
            res.second_char    = pair_rdata[6:0];
            res.pair_valid     = 1'b1;
            res.last           = (k_next == n_ff);
            if (res_ready) begin
               res_load = 1'b1;
               if (k_next == n_ff) begin
                  state_in = XPA_S_IDLE;
               end else begin
                  pair_re = 1'b1;
                  k_in    = k_next;
               end
            end
         end

         XPA_S_RESP: begin
            if (res_ready) begin
               res_load = 1'b1;
               state_in = XPA_S_IDLE;
            end
         end

         default: begin
            state_in = XPA_S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/xpa_checker.sv */
// Port-level checker for the XDS packet assembler, bound to the top level.
// Uses xpa_pkg and the macros of xds_packet_assembler_defines.svh.
`include "xds_packet_assembler_defines.svh"

module xpa_checker
   import xpa_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [1:0] rsp_detail,
   input logic [3:0] rsp_packet_class,
   input logic [6:0] rsp_packet_type,
   input logic [5:0] rsp_payload_length,
   input logic [6:0] rsp_first_char,
   input logic [6:0] rsp_second_char,
   input logic       rsp_pair_valid,
   input logic       rsp_last
);

   logic        req_acc;
   logic        rsp_acc;
   logic [1:0]  open_ff;
   logic        run_ff;
   logic [3:0]  run_class_ff;
   logic [6:0]  run_type_ff;
   logic [36:0] rsp_bits;
   logic        run_same;
   logic        single_ok;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   assign rsp_bits  = {rsp_status, rsp_detail, rsp_packet_class, rsp_packet_type,
                       rsp_payload_length, rsp_first_char, rsp_second_char,
                       rsp_pair_valid, rsp_last};
   assign run_same  = (rsp_status == XPA_ST_READY) && rsp_pair_valid &&
                      (rsp_packet_class == run_class_ff) &&
                      (rsp_packet_type == run_type_ff);
   assign single_ok = rsp_last && !rsp_pair_valid && (rsp_payload_length == 6'd0);

   // Count words taken whose final result has not left yet
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 2'd0;
         run_ff  <= 1'b0;
      end else begin
         open_ff <= open_ff + {1'b0, req_acc} - {1'b0, rsp_acc && rsp_last};
         if (rsp_acc) begin
            run_ff <= (rsp_status == XPA_ST_READY) && !rsp_last;
         end
      end
      if (rsp_acc) begin
         run_class_ff <= rsp_packet_class;
         run_type_ff  <= rsp_packet_type;
      end
   end

   `XPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bits))
   `XPA_ASSERT_NEXT(a_one_word, req_acc, req_stall)
   `XPA_ASSERT_IMP(a_no_orphan, rsp_acc, (open_ff != 2'd0) && (open_ff != 2'd3))
   `XPA_ASSERT_IMP(a_run_cont, rsp_valid && run_ff, run_same)
   `XPA_ASSERT_IMP(a_single, rsp_valid && (rsp_status != XPA_ST_READY), single_ok)

endmodule

bind xds_packet_assembler xpa_checker u_checker (.*);
